// File: sv/fewq_pkg.sv
`default_nettype none

package fewq_pkg;

  // Operation codes carried in the mode field.
  localparam logic ModeInsert = 1'b0;
  localparam logic ModePop    = 1'b1;

  // Ordering policy codes held in the configuration register.
  localparam logic PolicyFifo = 1'b0;
  localparam logic PolicyEdf  = 1'b1;

  localparam int unsigned IdW  = 8;
  localparam int unsigned KeyW = 32;
  localparam int unsigned OccW = 5;

  // One input beat.
  typedef struct packed {
    logic            mode;
    logic [IdW-1:0]  requester_id;
    logic [KeyW-1:0] last_compile_time;
  } fewq_in_t;

  // One result beat.
  typedef struct packed {
    logic [IdW-1:0]  popped_id;
    logic            pop_valid;
    logic            insert_dropped;
    logic [OccW-1:0] occupancy;
  } fewq_out_t;

  // One queue entry as held in a cell.
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } fewq_entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins;
    logic            pop;
    logic            edf;
    logic [IdW-1:0]  new_id;
    logic [KeyW-1:0] new_key;
  } fewq_cmd_t;

endpackage

`default_nettype wire

// File: sv/fewq_cell.sv
`default_nettype none

module fewq_cell import fewq_pkg::*; (
  input  wire         clk_i,
  input  fewq_cmd_t   cmd_i,
  input  wire         occupied_i,
  input  wire         prev_hit_i,
  input  fewq_entry_t left_i,
  input  fewq_entry_t right_i,
  output logic        hit_o,
  output fewq_entry_t entry_o
);

  fewq_entry_t entry_q;
  fewq_entry_t entry_d;
  logic        own_hit;

  // This cell is the insert point if it is empty or, under EDF, holds a
  // strictly greater key. The hit ripples down so that only the first one counts.
  assign own_hit = !occupied_i || (cmd_i.edf && (cmd_i.new_key < entry_q.key));
  assign hit_o   = prev_hit_i || own_hit;

  // Next entry: shift toward the tail behind the insert point, take the new
  // entry at the insert point, or shift toward the head on a pop.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (prev_hit_i) begin
        entry_d = left_i;
      end else if (own_hit) begin
        entry_d.id  = cmd_i.new_id;
        entry_d.key = cmd_i.new_key;
      end
    end else if (cmd_i.pop) begin
      entry_d = right_i;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: sv/fifo_or_edf_wait_queue_top.sv
`default_nettype none

// Channel | Signals                           | Direction
// --------+-----------------------------------+----------
// in      | in_valid_i, in_ready_o, in_data_i | request beats into the queue
// out     | out_valid_o, out_ready_i, out_data_o | one result beat per request
// cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i | policy register write
//
// Each request is handled at once: all cells compare the new key in parallel
// and the row shifts on the same edge, so a beat can be taken every cycle.
// The result sits in an output register; a new beat is taken whenever that
// register is empty or being drained, so out_ready_i low stalls the input.
// Reset empties the queue and selects FIFO policy; there is no clearing pass.

module fifo_or_edf_wait_queue_top import fewq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  fewq_in_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output fewq_out_t out_data_o,
  input  wire       cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire       cfg_data_i
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            policy_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            out_valid_q;
  fewq_out_t       out_data_q;
  fewq_out_t       out_data_d;

  logic            in_fire;
  logic            full;
  logic            empty;
  fewq_cmd_t       cmd;

  logic        [DEPTH-1:0] occupied;
  logic        [DEPTH-1:0] hit;
  fewq_entry_t [DEPTH-1:0] entries;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign full        = (count_q == CntW'(DEPTH));
  assign empty       = (count_q == '0);

  // Command to the cell row; refused operations leave the cells alone.
  always_comb begin
    cmd.ins     = in_fire && (in_data_i.mode == ModeInsert) && !full;
    cmd.pop     = in_fire && (in_data_i.mode == ModePop) && !empty;
    cmd.edf     = (policy_q == PolicyEdf);
    cmd.new_id  = in_data_i.requester_id;
    cmd.new_key = in_data_i.last_compile_time;
  end

  // The row of cells, head at index 0.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    fewq_entry_t left_e;
    fewq_entry_t right_e;
    logic        prev_hit;

    assign occupied[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign left_e   = '0;
      assign prev_hit = 1'b0;
    end else begin : g_mid
      assign left_e   = entries[g-1];
      assign prev_hit = hit[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = entries[g+1];
    end

    fewq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (occupied[g]),
      .prev_hit_i (prev_hit),
      .left_i     (left_e),
      .right_i    (right_e),
      .hit_o      (hit[g]),
      .entry_o    (entries[g])
    );
  end

  // Entry count and the result of the beat being taken.
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CntW'(1);
    end
    out_data_d.popped_id      = cmd.pop ? entries[0].id : '0;
    out_data_d.pop_valid      = cmd.pop;
    out_data_d.insert_dropped = in_fire && (in_data_i.mode == ModeInsert) && full;
    out_data_d.occupancy      = OccW'(count_d);
  end

  // Control state, policy register and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= PolicyFifo;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        policy_q <= cfg_data_i;
      end
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
        out_data_q  <= out_data_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  // A result never reports both a pop and a dropped insert.
  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.pop_valid && out_data_o.insert_dropped))
    else $error("pop and drop flagged together");

  // A pop on a non-empty queue lowers the count by one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.mode == ModePop) && !empty)
      |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("pop did not lower the count");

  // An insert into a full queue is flagged and leaves the count unchanged.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.mode == ModeInsert) && full)
      |=> (out_data_o.insert_dropped && full))
    else $error("insert into full queue not dropped");
`endif

endmodule

`default_nettype wire
